FILE: sv/nv12_pkg.sv
// nv12_pkg: shared types and constants of the NV12 to BGR converter.
// No dependencies; used by every module of the block but nv12_ram.
package nv12_pkg;

   localparam int PIX_W      = 8;
   localparam int PPR_W      = 11;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int PROD_W     = 18;
   localparam int SUM_W      = 20;

   localparam logic [PPR_W-1:0]      PPR_RESET          = 11'd320;
   localparam logic [CSR_ADDR_W-1:0] ADDR_PAIRS_PER_ROW = 2'd0;

   // BT.601 limited-range coefficients, 8 fractional bits
   localparam logic signed [10:0] OFFSET_Y = 11'sd16;
   localparam logic signed [10:0] OFFSET_C = 11'sd128;
   localparam logic signed [10:0] ROUND    = 11'sd128;
   localparam logic signed [10:0] COEF_Y   = 11'sd298;
   localparam logic signed [10:0] COEF_BU  = 11'sd516;
   localparam logic signed [10:0] COEF_GU  = 11'sd100;
   localparam logic signed [10:0] COEF_GV  = 11'sd208;
   localparam logic signed [10:0] COEF_RV  = 11'sd409;

   // one input pair, first field in the highest bits
   typedef struct packed {
      logic [PIX_W-1:0] chroma_red;
      logic [PIX_W-1:0] chroma_blue;
      logic [PIX_W-1:0] luma_right;
      logic [PIX_W-1:0] luma_left;
   } pair_type;

   // one result pair, first field in the highest bits
   typedef struct packed {
      logic [PIX_W-1:0] red_right;
      logic [PIX_W-1:0] green_right;
      logic [PIX_W-1:0] blue_right;
      logic [PIX_W-1:0] red_left;
      logic [PIX_W-1:0] green_left;
      logic [PIX_W-1:0] blue_left;
   } bgr_type;

endpackage

FILE: sv/nv12_ram.sv
// nv12_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module nv12_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/nv12_color.sv
// nv12_color: two-stage BT.601 color math (products, then sums and clamp)
// ending in the output register. Depends on nv12_pkg.
module nv12_color (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  nv12_pkg::pair_type in_pair,
   output logic               out_valid,
   input  logic               out_ready,
   output nv12_pkg::bgr_type  out_bgr
);

   localparam int PW = nv12_pkg::PROD_W;
   localparam int SW = nv12_pkg::SUM_W;

   // product stage
   logic                 prod_valid_ff, prod_valid_in;
   logic signed [PW-1:0] yl_ff, yr_ff, bu_ff, gu_ff, gv_ff, rv_ff;
   logic signed [8:0]    yl_off, yr_off, u_off, v_off;
   // output stage
   logic                 out_valid_ff, out_valid_in;
   nv12_pkg::bgr_type    out_bgr_ff, out_bgr_in;
   logic                 adv_prod, adv_out;
   logic signed [SW-1:0] b_l, g_l, r_l, b_r, g_r, r_r;

   function automatic logic [nv12_pkg::PIX_W-1:0] saturate(input logic signed [SW-1:0] s);
      logic [nv12_pkg::PIX_W-1:0] r;
      if (s[SW-1]) begin
         r = '0;
      end else if (|s[SW-2:16]) begin
         r = '1;
      end else begin
         r = s[15:8];
      end
      return r;
   endfunction

   assign adv_out  = !out_valid_ff || out_ready;
   assign adv_prod = !prod_valid_ff || adv_out;
   assign in_ready = adv_prod;

   always_comb begin
      yl_off = $signed({1'b0, in_pair.luma_left})   - 9'(nv12_pkg::OFFSET_Y);
      yr_off = $signed({1'b0, in_pair.luma_right})  - 9'(nv12_pkg::OFFSET_Y);
      u_off  = $signed({1'b0, in_pair.chroma_blue}) - 9'(nv12_pkg::OFFSET_C);
      v_off  = $signed({1'b0, in_pair.chroma_red})  - 9'(nv12_pkg::OFFSET_C);
      prod_valid_in = adv_prod ? in_valid : prod_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_prod) begin
         yl_ff <= PW'(yl_off) * PW'(nv12_pkg::COEF_Y);
         yr_ff <= PW'(yr_off) * PW'(nv12_pkg::COEF_Y);
         bu_ff <= PW'(u_off)  * PW'(nv12_pkg::COEF_BU);
         gu_ff <= PW'(u_off)  * PW'(nv12_pkg::COEF_GU);
         gv_ff <= PW'(v_off)  * PW'(nv12_pkg::COEF_GV);
         rv_ff <= PW'(v_off)  * PW'(nv12_pkg::COEF_RV);
      end
   end

   always_comb begin
      b_l = SW'(yl_ff) + SW'(bu_ff) + SW'(nv12_pkg::ROUND);
      g_l = SW'(yl_ff) - SW'(gu_ff) - SW'(gv_ff) + SW'(nv12_pkg::ROUND);
      r_l = SW'(yl_ff) + SW'(rv_ff) + SW'(nv12_pkg::ROUND);
      b_r = SW'(yr_ff) + SW'(bu_ff) + SW'(nv12_pkg::ROUND);
      g_r = SW'(yr_ff) - SW'(gu_ff) - SW'(gv_ff) + SW'(nv12_pkg::ROUND);
      r_r = SW'(yr_ff) + SW'(rv_ff) + SW'(nv12_pkg::ROUND);
      out_bgr_in.blue_left   = saturate(b_l);
      out_bgr_in.green_left  = saturate(g_l);
      out_bgr_in.red_left    = saturate(r_l);
      out_bgr_in.blue_right  = saturate(b_r);
      out_bgr_in.green_right = saturate(g_r);
      out_bgr_in.red_right   = saturate(r_r);
      out_valid_in = adv_out ? prod_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out) begin
         out_bgr_ff <= out_bgr_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_bgr   = out_bgr_ff;

endmodule

FILE: sv/nv12_to_bgra_converter.sv
// nv12_to_bgra_converter: NV12 pixel-pair stream to BGR, BT.601 limited range.
// Depends on nv12_pkg, nv12_ram (chroma line store) and nv12_color.
// Pipeline: an accepted pair passes the input and line-store read stage, the
// product stage and the sum/clamp output register before rsp_tvalid rises.
// Throughput: one pixel pair per cycle, sustained while rsp_tready stays high.
// Reset: clears column, row parity and the pipeline, sets pairs_per_row to 320;
// the line store is not cleared and must be written by an even row first.
module nv12_to_bgra_converter #(
   parameter int MAX_PAIRS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: luma_left, luma_right, chroma_blue, chroma_red
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,
   // req_tuser: frame_start
   input  logic                                req_tuser,
   // rsp_tdata: blue_left, green_left, red_left, blue_right, green_right, red_right
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [47:0]                         rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nv12_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [nv12_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [nv12_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int COL_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int CMP_W = (COL_W + 1 > nv12_pkg::PPR_W) ? COL_W + 1 : nv12_pkg::PPR_W;
   localparam int CHR_W = 2 * nv12_pkg::PIX_W;

   logic [nv12_pkg::PPR_W-1:0] ppr_ff, ppr_in;
   logic [COL_W-1:0]           column_ff, column_in, col_cur;
   logic                       odd_ff, odd_in, odd_cur;
   logic [CMP_W-1:0]           len_eff, col_inc;
   logic                       accept, csr_write;

   nv12_pkg::pair_type         in_pair, s1_pair_ff, color_pair;
   logic                       s1_valid_ff, s1_valid_in, s1_odd_ff;
   logic                       color_ready, adv_s1;
   logic [CHR_W-1:0]           line_rd_data;
   nv12_pkg::bgr_type          out_bgr;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == nv12_pkg::ADDR_PAIRS_PER_ROW)
                       ? nv12_pkg::CSR_DATA_W'(ppr_ff) : '0;
   assign ppr_in     = (csr_write && csr_paddr == nv12_pkg::ADDR_PAIRS_PER_ROW)
                       ? csr_pwdata[nv12_pkg::PPR_W-1:0] : ppr_ff;

   // input side: column / parity tracking and line-store access
   assign in_pair    = nv12_pkg::pair_type'(req_tdata);
   assign adv_s1     = !s1_valid_ff || color_ready;
   assign req_tready = adv_s1;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      col_cur = req_tuser ? '0 : column_ff;
      odd_cur = req_tuser ? 1'b0 : odd_ff;
      if (ppr_ff == '0) begin
         len_eff = CMP_W'(1);
      end else if (CMP_W'(ppr_ff) > CMP_W'(MAX_PAIRS)) begin
         len_eff = CMP_W'(MAX_PAIRS);
      end else begin
         len_eff = CMP_W'(ppr_ff);
      end
      col_inc   = CMP_W'(col_cur) + CMP_W'(1);
      column_in = column_ff;
      odd_in    = odd_ff;
      if (accept) begin
         if (col_inc >= len_eff) begin
            column_in = '0;
            odd_in    = !odd_cur;
         end else begin
            column_in = col_inc[COL_W-1:0];
            odd_in    = odd_cur;
         end
      end
      s1_valid_in = adv_s1 ? req_tvalid : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppr_ff      <= nv12_pkg::PPR_RESET;
         column_ff   <= '0;
         odd_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         ppr_ff      <= ppr_in;
         column_ff   <= column_in;
         odd_ff      <= odd_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pair_ff <= in_pair;
         s1_odd_ff  <= odd_cur;
      end
   end

   // Even rows write their chroma, odd rows read it back. A write and the read
   // of the same entry never fall on the same accept, so no forwarding needed.
   // Read data holds while stage 1 stalls since reads happen only on accept.
   nv12_ram #(
      .WIDTH (CHR_W),
      .DEPTH (MAX_PAIRS)
   ) u_line (
      .clock   (clock),
      .wr_en   (accept && !odd_cur),
      .wr_addr (col_cur),
      .wr_data ({in_pair.chroma_red, in_pair.chroma_blue}),
      .rd_en   (accept && odd_cur),
      .rd_addr (col_cur),
      .rd_data (line_rd_data)
   );

   always_comb begin
      color_pair = s1_pair_ff;
      if (s1_odd_ff) begin
         color_pair.chroma_blue = line_rd_data[nv12_pkg::PIX_W-1:0];
         color_pair.chroma_red  = line_rd_data[CHR_W-1:nv12_pkg::PIX_W];
      end
   end

   nv12_color u_color (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (color_ready),
      .in_pair   (color_pair),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_bgr   (out_bgr)
   );

   assign rsp_tdata = 48'(out_bgr);

endmodule

FILE: sv/nv12_checker.sv
// nv12_checker: port-level assertions for nv12_to_bgra_converter, bound to it.
// Depends on nv12_pkg and the converter's port list.
module nv12_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [47:0]                     rsp_tdata,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic [nv12_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [nv12_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [nv12_pkg::CSR_DATA_W-1:0] csr_prdata,
   input logic                            csr_pready
);

   // a stalled result transfer keeps its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp data changed while stalled");

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // with nothing waiting on the result side, the input side takes data
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output");

   // written row length reads back
   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready
      && csr_paddr == nv12_pkg::ADDR_PAIRS_PER_ROW
      |=> csr_paddr != nv12_pkg::ADDR_PAIRS_PER_ROW
          || csr_prdata[nv12_pkg::PPR_W-1:0] == $past(csr_pwdata[nv12_pkg::PPR_W-1:0]))
      else $error("pairs_per_row readback mismatch");

endmodule

bind nv12_to_bgra_converter nv12_checker u_nv12_checker (.*);

FILE: bench/tb_nv12_to_bgra_converter.sv
// tb_nv12_to_bgra_converter: self-checking bench for the NV12 to BGR converter.
// Depends on nv12_pkg and nv12_to_bgra_converter. A built-in model predicts
// each result pair; stream sides are throttled at random.
module tb_nv12_to_bgra_converter;

   localparam int LINE_DEPTH  = 1024;
   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 200;

   // {chroma_red, chroma_blue, luma_right, luma_left}
   localparam logic [31:0] CORNER_PAIRS [12] = '{
      32'h0000_FF00, 32'hFFFF_00FF, 32'h8080_EB10, 32'hFF00_FFFF,
      32'h00FF_0000, 32'h00FF_8080, 32'hFF00_10EB, 32'hFFFF_FFFF,
      32'h0000_0000, 32'h10F0_1010, 32'hF010_EBEB, 32'h817F_FE01
   };

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [31:0]                     req_tdata   = '0;   // luma_left, luma_right, cb, cr
   logic                            req_tuser   = 1'b0; // frame_start
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [47:0]                     rsp_tdata;          // blue/green/red left, then right
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [nv12_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [nv12_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [nv12_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   nv12_to_bgra_converter uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // converter state as the bench sees it
   logic [nv12_pkg::PPR_W-1:0] row_len_reg = nv12_pkg::PPR_RESET;
   int unsigned                col_pos     = 0;
   bit                         odd_row     = 1'b0;
   logic [15:0]                chroma_store [LINE_DEPTH];
   bit                         chroma_written [LINE_DEPTH];
   nv12_pkg::bgr_type          pending_bgr [$];
   int                         errors      = 0;

   // traffic shaping
   int gap_max    = 0;
   int burst_left = 0;
   int stall_max  = 0;
   int hold_token = 0;
   bit offering   = 1'b0;

   int                hold_seen = 0;
   int                hold_left = 0;
   int                run_left  = 0;
   bit                ready_run = 1'b0;
   nv12_pkg::bgr_type rsp_word;
   nv12_pkg::bgr_type want_word;

   function automatic logic [7:0] clamp_byte(input int sum);
      if (sum < 0) return 8'd0;
      if (sum >= 65536) return 8'd255;
      return sum[15:8];
   endfunction

   // returns {red, green, blue}
   function automatic logic [23:0] pixel_bgr(input logic [7:0] luma, input logic [7:0] cb,
                                             input logic [7:0] cr);
      int yy, u, v;
      yy = (int'(luma) - 16) * 298;
      u  = int'(cb) - 128;
      v  = int'(cr) - 128;
      return {clamp_byte(yy + 409 * v + 128),
              clamp_byte(yy - 100 * u - 208 * v + 128),
              clamp_byte(yy + 516 * u + 128)};
   endfunction

   task automatic wait_for_results();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
         @(posedge clock);
      end
      while (pending_bgr.size() != 0) @(posedge clock);
   endtask

   task automatic send_pair(input bit frame_start, input nv12_pkg::pair_type pix);
      nv12_pkg::bgr_type exp_bgr;
      logic [7:0]        cb, cr;
      bit                fs;
      int unsigned       len;
      fs = frame_start;
      // an odd row may only reuse chroma that an even row stored before
      if (!fs && odd_row && !chroma_written[col_pos]) fs = 1'b1;
      req_tvalid <= 1'b1;
      req_tuser  <= fs;
      req_tdata  <= pix;
      offering = 1'b1;
      do @(posedge clock); while (!req_tready);

      len = (row_len_reg == 0) ? 1 : (row_len_reg > LINE_DEPTH) ? LINE_DEPTH : row_len_reg;
      if (fs) begin
         col_pos = 0;
         odd_row = 1'b0;
      end
      if (!odd_row) begin
         cb = pix.chroma_blue;
         cr = pix.chroma_red;
         chroma_store[col_pos]   = {cr, cb};
         chroma_written[col_pos] = 1'b1;
      end else begin
         {cr, cb} = chroma_store[col_pos];
      end
      {exp_bgr.red_left, exp_bgr.green_left, exp_bgr.blue_left} =
         pixel_bgr(pix.luma_left, cb, cr);
      {exp_bgr.red_right, exp_bgr.green_right, exp_bgr.blue_right} =
         pixel_bgr(pix.luma_right, cb, cr);
      pending_bgr.insert(pending_bgr.size(), exp_bgr);
      // a shortened row wraps as soon as the next column reaches its end
      if (col_pos + 1 >= len) begin
         col_pos = 0;
         odd_row = !odd_row;
      end else begin
         col_pos++;
      end

      if (gap_max > 0) begin
         if (burst_left == 0) burst_left = $urandom_range(1, 24);
         burst_left--;
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end
   endtask

   task automatic csr_cycle(input bit write, input logic [nv12_pkg::CSR_DATA_W-1:0] word,
                            output logic [nv12_pkg::CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= nv12_pkg::ADDR_PAIRS_PER_ROW;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_row_length();
      logic [nv12_pkg::CSR_DATA_W-1:0] rdata;
      csr_cycle(1'b0, '0, rdata);
      if (rdata !== {{(nv12_pkg::CSR_DATA_W - nv12_pkg::PPR_W){1'b0}}, row_len_reg}) begin
         errors++;
         $display("%0t: pairs_per_row readback expected %0d, actual %0d",
                  $time, row_len_reg, rdata);
      end
   endtask

   task automatic write_row_length(input logic [nv12_pkg::CSR_DATA_W-1:0] word);
      logic [nv12_pkg::CSR_DATA_W-1:0] rdata;
      wait_for_results();
      csr_cycle(1'b1, word, rdata);
      row_len_reg = word[nv12_pkg::PPR_W-1:0];
      check_row_length();
   endtask

   task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_word = rsp_tdata;
         if (pending_bgr.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
         end else begin
            want_word = pending_bgr[0];
            pending_bgr.delete(0);
            compare_field("blue_left",   want_word.blue_left,   rsp_word.blue_left);
            compare_field("green_left",  want_word.green_left,  rsp_word.green_left);
            compare_field("red_left",    want_word.red_left,    rsp_word.red_left);
            compare_field("blue_right",  want_word.blue_right,  rsp_word.blue_right);
            compare_field("green_right", want_word.green_right, rsp_word.green_right);
            compare_field("red_right",   want_word.red_right,   rsp_word.red_right);
         end
      end
   end

   // receiver: alternating ready and stall runs, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (run_left == 0) begin
            ready_run = (stall_max == 0) ? 1'b1 : !ready_run;
            run_left  = ready_run ? $urandom_range(1, 16) : $urandom_range(1, stall_max);
         end
         run_left--;
         rsp_tready <= ready_run;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // reset row length: one full even row of 320 pairs, then the odd row starts
   task automatic test_reset_row_length();
      int i;
      stall_max = 3;
      gap_max   = 4;
      check_row_length();
      for (i = 0; i < 328; i++) send_pair(i == 0, nv12_pkg::pair_type'($urandom));
      wait_for_results();
   endtask

   task automatic test_color_corners();
      int                 i;
      nv12_pkg::pair_type pix;
      stall_max = 0;
      gap_max   = 0;
      write_row_length(12);
      for (i = 0; i < 12; i++) send_pair(i == 0, CORNER_PAIRS[i]);
      // odd row: the transfer's own chroma must be ignored
      for (i = 0; i < 12; i++) begin
         pix = CORNER_PAIRS[11 - i];
         pix.chroma_blue = $urandom;
         pix.chroma_red  = $urandom;
         send_pair(1'b0, pix);
      end
      wait_for_results();
   endtask

   task automatic test_row_length_limits();
      int i;
      stall_max = 2;
      gap_max   = 0;
      write_row_length(0);            // behaves as one pair per row
      for (i = 0; i < 6; i++) send_pair(i == 0, nv12_pkg::pair_type'($urandom));
      write_row_length(1);
      for (i = 0; i < 6; i++) send_pair(i == 0, nv12_pkg::pair_type'($urandom));
      write_row_length(2047);         // clipped to the line store depth
      for (i = 0; i < LINE_DEPTH + 12; i++)
         send_pair(i == 0, nv12_pkg::pair_type'($urandom));
      write_row_length(1025);
      for (i = 0; i < 8; i++) send_pair(i == 0, nv12_pkg::pair_type'($urandom));
      write_row_length(32'hFFFF_F803); // upper bits dropped, row of 3
      for (i = 0; i < 10; i++) send_pair(1'b0, nv12_pkg::pair_type'($urandom));
      wait_for_results();
   endtask

   task automatic test_row_length_change();
      int i;
      stall_max = 4;
      gap_max   = 3;
      write_row_length(8);
      for (i = 0; i < 5; i++) send_pair(i == 0, nv12_pkg::pair_type'($urandom));
      write_row_length(3);            // column already past the new end
      for (i = 0; i < 6; i++) send_pair(1'b0, nv12_pkg::pair_type'($urandom));
      write_row_length(12);
      for (i = 0; i < 14; i++) send_pair(1'b0, nv12_pkg::pair_type'($urandom));
      wait_for_results();
   endtask

   task automatic test_output_backpressure();
      int i;
      stall_max = 0;
      gap_max   = 0;
      write_row_length(16);
      hold_token++;
      for (i = 0; i < 80; i++) send_pair(i == 0, nv12_pkg::pair_type'($urandom));
      wait_for_results();
   endtask

   task automatic test_random_frames(input int total);
      int          sent, count, pick, i;
      int unsigned len;
      sent = 0;
      while (sent < total) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            len = 0;
         else if (pick == 1)
            len = $urandom_range(LINE_DEPTH + 1, 2047);
         else if (pick < 5)
            len = $urandom_range(17, 64);
         else
            len = $urandom_range(1, 16);
         stall_max = $urandom_range(0, 8);
         gap_max   = $urandom_range(0, 6);
         write_row_length(($urandom & ~32'h7FF) | len);
         count = (len > 64) ? 20 : $urandom_range(30, 120);
         // mostly whole frames; a stray frame start now and then breaks a row
         for (i = 0; i < count; i++)
            send_pair(i == 0 || $urandom_range(0, 63) == 0, nv12_pkg::pair_type'($urandom));
         sent += count;
      end
      wait_for_results();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_row_length();
      test_color_corners();
      test_row_length_limits();
      test_row_length_change();
      test_output_backpressure();
      test_random_frames(700);
      wait_for_results();
      repeat (8) @(posedge clock);
      if (errors == 0 && pending_bgr.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
